// ===== src/wdtkl_pkg.sv =====
// ----------------------------------------------------------------------------
// wdtkl_pkg
// Shared types and constants for the watchdog timer with feed and lock keys.
// ----------------------------------------------------------------------------
package wdtkl_pkg;

    // Item kinds on the input channel
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } wdtkl_op_t;

    // Register byte offsets
    localparam logic [11:0] OFF_CTRL = 12'h000;
    localparam logic [11:0] OFF_LOAD = 12'h004;
    localparam logic [11:0] OFF_VAL  = 12'h008;
    localparam logic [11:0] OFF_KEY  = 12'h00C;
    localparam logic [11:0] OFF_SR   = 12'h010;

    // Key register codes
    localparam logic [31:0] KEY_FEED = 32'h5A5A_5A5A;
    localparam logic [31:0] KEY_LOCK = 32'h1ACC_E551;

    // Input item: bus read, bus write or one-microsecond tick
    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] addr;
        logic [31:0] wdata;
    } wdtkl_in_t;

    // Result item
    typedef struct packed {
        logic [31:0] rdata;
        logic        irq;
    } wdtkl_out_t;

endpackage

// ===== src/watchdog_timer_with_key_lock_unit.sv =====
// ----------------------------------------------------------------------------
// watchdog_timer_with_key_lock_unit
// Register-mapped watchdog: bus reads, bus writes and ticks arrive as items,
// each item returns one result with read data and the interrupt line.
//
//   channel | ports                      | direction | payload
//   --------+----------------------------+-----------+-------------------------
//   input   | s_valid, s_ready, s_data   | in        | op, addr, wdata
//   result  | m_valid, m_ready, m_data   | out       | rdata, irq
//
// Every item is held in the input register after acceptance, then passes
// through the register update into the result register.
// One item per cycle is accepted while the result side keeps taking items.
// A stalled result holds the update stage; the input register still takes
// one more item, then s_ready drops until the result side moves.
// Synchronous active-low reset clears all watchdog state to zero.
// ----------------------------------------------------------------------------
module watchdog_timer_with_key_lock_unit
    import wdtkl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  wdtkl_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output wdtkl_out_t m_data
);

    // Pipeline registers
    logic       in_valid_reg;
    wdtkl_in_t  in_item_reg;
    logic       out_valid_reg;
    wdtkl_out_t out_item_reg;

    // Watchdog state
    logic [31:0] reload_value_reg,   reload_value_next;
    logic        enable_reg,         enable_next;
    logic        int_enable_reg,     int_enable_next;
    logic        timeout_flag_reg,   timeout_flag_next;
    logic        lock_flag_reg,      lock_flag_next;
    logic        expired_flag_reg,   expired_flag_next;
    logic [31:0] down_count_reg,     down_count_next;
    logic [31:0] frozen_count_reg,   frozen_count_next;

    logic        advance;
    logic [31:0] cur_val;
    logic [31:0] tick_count;
    logic        ctrl_en;
    logic        restart;
    wdtkl_out_t  result;

    // Move the held item into the result register when it has room
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    // Value seen through VAL
    assign cur_val    = !enable_reg ? frozen_count_reg
                      : (expired_flag_reg ? 32'd0 : down_count_reg);
    assign tick_count = (down_count_reg != 32'd0) ? down_count_reg - 32'd1 : 32'd0;
    assign ctrl_en    = in_item_reg.wdata[0] | lock_flag_reg;

    // Register update and read data for the held item
    always_comb begin
        reload_value_next = reload_value_reg;
        enable_next       = enable_reg;
        int_enable_next   = int_enable_reg;
        timeout_flag_next = timeout_flag_reg;
        lock_flag_next    = lock_flag_reg;
        expired_flag_next = expired_flag_reg;
        down_count_next   = down_count_reg;
        frozen_count_next = frozen_count_reg;
        restart           = 1'b0;
        result.rdata      = 32'd0;

        case (in_item_reg.op)
            OP_READ: begin
                case (in_item_reg.addr)
                    OFF_CTRL: result.rdata = {30'd0, int_enable_reg, enable_reg};
                    OFF_LOAD: result.rdata = reload_value_reg;
                    OFF_VAL:  result.rdata = cur_val;
                    OFF_SR:   result.rdata = {31'd0, timeout_flag_reg};
                    default:  result.rdata = 32'd0;
                endcase
            end
            OP_WRITE: begin
                case (in_item_reg.addr)
                    OFF_CTRL: begin
                        // Freeze VAL on disable, restart on enable
                        if (enable_reg && !ctrl_en) begin
                            frozen_count_next = cur_val;
                        end
                        enable_next     = ctrl_en;
                        int_enable_next = in_item_reg.wdata[1];
                        restart         = !enable_reg && ctrl_en;
                    end
                    OFF_LOAD: reload_value_next = in_item_reg.wdata;
                    OFF_KEY: begin
                        if (in_item_reg.wdata == KEY_FEED) begin
                            restart = enable_reg;
                        end else if (in_item_reg.wdata == KEY_LOCK) begin
                            lock_flag_next = 1'b1;
                        end
                    end
                    OFF_SR: begin
                        if (in_item_reg.wdata[0]) begin
                            timeout_flag_next = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            OP_TICK: begin
                // Count down while enabled, expire at zero
                if (enable_reg && !expired_flag_reg) begin
                    down_count_next = tick_count;
                    if (tick_count == 32'd0) begin
                        expired_flag_next = 1'b1;
                        timeout_flag_next = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        // Reload the count from LOAD
        if (restart) begin
            down_count_next   = reload_value_reg;
            expired_flag_next = (reload_value_reg == 32'd0);
            if (reload_value_reg == 32'd0) begin
                timeout_flag_next = 1'b1;
            end
        end

        result.irq = timeout_flag_next & int_enable_next;
    end

    // Handshake control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_data;
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

    // Watchdog state, updated once per processed item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_value_reg <= 32'd0;
            enable_reg       <= 1'b0;
            int_enable_reg   <= 1'b0;
            timeout_flag_reg <= 1'b0;
            lock_flag_reg    <= 1'b0;
            expired_flag_reg <= 1'b0;
            down_count_reg   <= 32'd0;
            frozen_count_reg <= 32'd0;
        end else if (advance) begin
            reload_value_reg <= reload_value_next;
            enable_reg       <= enable_next;
            int_enable_reg   <= int_enable_next;
            timeout_flag_reg <= timeout_flag_next;
            lock_flag_reg    <= lock_flag_next;
            expired_flag_reg <= expired_flag_next;
            down_count_reg   <= down_count_next;
            frozen_count_reg <= frozen_count_next;
        end
    end

    // Interrupt in a fresh result matches the state it leaves behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (out_item_reg.irq == (timeout_flag_reg & int_enable_reg)))
        else $error("result irq disagrees with watchdog state");

    // Lock holds until reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        lock_flag_reg |=> lock_flag_reg)
        else $error("lock flag dropped without reset");

    // A CTRL write under lock keeps the watchdog enabled
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && lock_flag_reg && in_item_reg.op == OP_WRITE
         && in_item_reg.addr == OFF_CTRL) |=> enable_reg)
        else $error("CTRL write disabled a locked watchdog");

    // An expired count sits at zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        expired_flag_reg |-> (down_count_reg == 32'd0))
        else $error("expired watchdog with nonzero count");

endmodule
